/* sv/mshs_pkg.sv */
`default_nettype none

package mshs_pkg;

    // sizes of the peer table and of the attempt counter
    localparam int PEERS        = 16;
    localparam int MAX_ATTEMPTS = 8;
    localparam int IDX_W        = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int CNT_W        = $clog2(PEERS + 1);
    localparam int ATT_W        = $clog2(MAX_ATTEMPTS + 1);

    // field widths fixed by the interface
    localparam int FUNC_W    = 2;
    localparam int TS_W      = 32;
    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int RID_W     = 8;
    localparam int OUT_ID_W  = 4;
    localparam int OUT_CNT_W = 5;
    localparam int RCV_W     = 5;
    localparam int RETRY_W   = 8;
    localparam int RTO_W     = 16;
    localparam int CMP_W     = (CNT_W > RCV_W) ? CNT_W : RCV_W;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_EXPECTED = 2'd0;
    localparam logic [1:0] REG_RETRIES  = 2'd1;
    localparam logic [1:0] REG_RTO      = 2'd2;

    // reset values of the configuration registers
    localparam logic [RCV_W-1:0]   EXPECTED_RST = RCV_W'(1);
    localparam logic [RETRY_W-1:0] RETRIES_RST  = RETRY_W'(3);
    localparam logic [RTO_W-1:0]   RTO_RST      = RTO_W'(100);

    // request function codes
    localparam logic [FUNC_W-1:0] FN_START = 2'd0;
    localparam logic [FUNC_W-1:0] FN_TICK  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_PKT   = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_SYN   = 3'd1,
        ACT_START = 3'd2,
        ACT_PEER  = 3'd3,
        ACT_FAIL  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DONE = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_LIST = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [RCV_W-1:0]   need_peers;
        logic [RETRY_W-1:0] retries;
        logic [RTO_W-1:0]   rto_ticks;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } peer_t;

    typedef struct packed {
        action_t          action;
        logic [ATT_W-1:0] id;
        logic [TS_W-1:0]  ts;
        logic [CNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        action_t              action;
        logic [OUT_ID_W-1:0]  id;
        logic [TS_W-1:0]      ts;
        logic [OUT_CNT_W-1:0] count;
        logic [ADDR_W-1:0]    addr;
        logic [PORT_W-1:0]    port;
        logic                 last;
    } res_t;

endpackage

`default_nettype wire

/* sv/mshs_if.sv */
`default_nettype none

// request channel into the block
interface mshs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic        checksum_ok;
    logic        has_syn;
    logic        has_ack;
    logic [7:0]  pkt_retrans_id;
    logic [31:0] pkt_echo_ts;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;

    modport source (
        output valid, func, now_ms, checksum_ok, has_syn, has_ack,
               pkt_retrans_id, pkt_echo_ts, peer_addr, peer_port,
        input  ready
    );
    modport sink (
        input  valid, func, now_ms, checksum_ok, has_syn, has_ack,
               pkt_retrans_id, pkt_echo_ts, peer_addr, peer_port,
        output ready
    );
endinterface

// result channel out of the block
interface mshs_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [3:0]  syn_retrans_id;
    logic [31:0] syn_ts;
    logic [4:0]  cohort_count;
    logic [31:0] out_peer_addr;
    logic [15:0] out_peer_port;
    logic        last;

    modport source (
        output valid, action, syn_retrans_id, syn_ts, cohort_count,
               out_peer_addr, out_peer_port, last,
        input  ready
    );
    modport sink (
        input  valid, action, syn_retrans_id, syn_ts, cohort_count,
               out_peer_addr, out_peer_port, last,
        output ready
    );
endinterface

`default_nettype wire

/* sv/mshs_front.sv */
`default_nettype none

module mshs_front
    import mshs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    mshs_req_if.sink              item,
    input  wire cfg_t             cfg,
    output logic                  push,
    output cmd_t                  cmd,
    input  wire logic             q_full,
    input  wire logic             list_done,
    input  wire logic [IDX_W-1:0] rd_idx,
    output peer_t                 rd_peer
);

    phase_t            phase_reg, phase_next;
    logic [ATT_W-1:0]  attempt_reg, attempt_next;
    logic [TS_W-1:0]   sent_ts_reg, sent_ts_next;
    logic [RTO_W-1:0]  ticks_reg, ticks_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              busy_reg, busy_next;
    peer_t             tab_reg [PEERS];

    logic              acc;
    logic              is_start, is_tick, is_pkt;
    logic [RTO_W-1:0]  ticks_dec;
    logic              expired;
    logic [ATT_W-1:0]  limit;
    logic              retry, give_up;
    logic              start_fail, start_go;
    logic              pkt_ok, seen, add;
    logic [PEERS-1:0]  hit;
    logic [CNT_W-1:0]  count_inc;
    logic              reached;
    logic              tab_we;

    // requests are held off while the queue is full or a full cohort is still being listed
    assign item.ready = !q_full && !busy_reg;
    assign acc        = item.valid && item.ready;

    assign rd_peer = tab_reg[rd_idx];

    // attempt limit: retries plus one, capped
    always_comb
    begin
        if ((RETRY_W + 1)'(cfg.retries) + (RETRY_W + 1)'(1) >= (RETRY_W + 1)'(MAX_ATTEMPTS))
        begin
            limit = ATT_W'(MAX_ATTEMPTS);
        end
        else
        begin
            limit = ATT_W'(cfg.retries + RETRY_W'(1));
        end
    end

    // duplicate compare against the collected peers
    always_comb
    begin
        for (int i = 0; i < PEERS; i++)
        begin
            hit[i] = (CNT_W'(i) < count_reg)
                  && (tab_reg[i].addr == item.peer_addr)
                  && (tab_reg[i].port == item.peer_port);
        end
    end
    assign seen = |hit;

    // classify the accepted request
    always_comb
    begin
        is_start   = acc && (item.func == FN_START);
        is_tick    = acc && (item.func == FN_TICK) && (phase_reg == PH_WAIT);
        is_pkt     = acc && (item.func == FN_PKT) && (phase_reg == PH_WAIT);
        start_fail = is_start && (cfg.need_peers == '0);
        start_go   = is_start && (cfg.need_peers != '0);
        ticks_dec  = (ticks_reg != '0) ? ticks_reg - RTO_W'(1) : '0;
        expired    = is_tick && (ticks_dec == '0);
        retry      = expired && (attempt_reg < limit);
        give_up    = expired && !(attempt_reg < limit);
        pkt_ok     = is_pkt && item.checksum_ok && item.has_syn && item.has_ack
                  && (item.pkt_retrans_id == RID_W'(attempt_reg))
                  && (item.pkt_echo_ts == sent_ts_reg);
        add        = pkt_ok && !seen && (count_reg < CNT_W'(PEERS));
        count_inc  = count_reg + CNT_W'(add);
        reached    = pkt_ok && (CMP_W'(count_inc) >= CMP_W'(cfg.need_peers));
    end

    // phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (start_fail || give_up)
        begin
            phase_next = PH_FAIL;
        end
        else if (start_go || retry)
        begin
            phase_next = PH_WAIT;
        end
        else if (reached)
        begin
            phase_next = PH_DONE;
        end
    end

    // state updates and commands for the back end
    always_comb
    begin
        attempt_next = attempt_reg;
        sent_ts_next = sent_ts_reg;
        ticks_next   = ticks_reg;
        count_next   = count_reg;
        busy_next    = busy_reg;
        tab_we       = 1'b0;
        push         = 1'b0;
        cmd          = '0;

        if (list_done)
        begin
            busy_next = 1'b0;
        end
        if (is_tick)
        begin
            ticks_next = ticks_dec;
        end

        if (start_fail)
        begin
            attempt_next = '0;
            count_next   = '0;
            push         = 1'b1;
            cmd.action   = ACT_FAIL;
        end
        else if (start_go || retry)
        begin
            attempt_next = start_go ? ATT_W'(1) : attempt_reg + ATT_W'(1);
            sent_ts_next = item.now_ms;
            ticks_next   = cfg.rto_ticks;
            count_next   = '0;
            push         = 1'b1;
            cmd.action   = ACT_SYN;
            cmd.id       = attempt_next;
            cmd.ts       = item.now_ms;
        end
        else if (give_up)
        begin
            push       = 1'b1;
            cmd.action = ACT_FAIL;
            cmd.id     = attempt_reg;
            cmd.count  = count_reg;
        end
        else if (pkt_ok)
        begin
            count_next = count_inc;
            tab_we     = add;
            if (reached)
            begin
                busy_next  = 1'b1;
                push       = 1'b1;
                cmd.action = ACT_START;
                cmd.id     = ATT_W'(1);
                cmd.ts     = item.now_ms;
                cmd.count  = count_inc;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            attempt_reg <= '0;
            sent_ts_reg <= '0;
            ticks_reg   <= '0;
            count_reg   <= '0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            attempt_reg <= attempt_next;
            sent_ts_reg <= sent_ts_next;
            ticks_reg   <= ticks_next;
            count_reg   <= count_next;
            busy_reg    <= busy_next;
        end
    end

    // peer table, written at the fill position
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_reg[count_reg[IDX_W-1:0]] <= '{addr: item.peer_addr, port: item.peer_port};
        end
    end

endmodule

`default_nettype wire

/* sv/mshs_queue.sv */
`default_nettype none

module mshs_queue
    import mshs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      pop_cmd
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full    = (fill_reg == (QPTR_W + 1)'(QDEPTH));
    assign valid   = (fill_reg != '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + (QPTR_W + 1)'(1);
            2'b01:   fill_next = fill_reg - (QPTR_W + 1)'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/mshs_back.sv */
`default_nettype none

module mshs_back
    import mshs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire cmd_t       q_cmd,
    output logic            pop,
    output logic [IDX_W-1:0] rd_idx,
    input  wire peer_t      rd_peer,
    output logic            list_done,
    mshs_res_if.source      result
);

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;
    logic             slot_free;
    logic             last_entry;
    logic             load;

    assign slot_free  = !res_valid_reg || result.ready;
    assign last_entry = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign rd_idx     = idx_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free && (q_cmd.action == ACT_START)
                    && (q_cmd.count != '0))
                begin
                    state_next = BK_LIST;
                end
            end
            BK_LIST:
            begin
                if (slot_free && last_entry)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // result building
    always_comb
    begin
        pop       = 1'b0;
        load      = 1'b0;
        list_done = 1'b0;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    pop            = 1'b1;
                    load           = 1'b1;
                    res_next       = '0;
                    res_next.action = q_cmd.action;
                    res_next.id    = OUT_ID_W'(q_cmd.id);
                    res_next.ts    = q_cmd.ts;
                    res_next.count = OUT_CNT_W'(q_cmd.count);
                    res_next.last  = (q_cmd.action != ACT_START) || (q_cmd.count == '0);
                    list_done      = (q_cmd.action == ACT_START) && (q_cmd.count == '0);
                    idx_next       = '0;
                    cnt_next       = q_cmd.count;
                end
            end
            BK_LIST:
            begin
                if (slot_free)
                begin
                    load           = 1'b1;
                    res_next       = '0;
                    res_next.action = ACT_PEER;
                    res_next.count = OUT_CNT_W'(cnt_reg);
                    res_next.addr  = rd_peer.addr;
                    res_next.port  = rd_peer.port;
                    res_next.last  = last_entry;
                    list_done      = last_entry;
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        res_valid_next = load ? 1'b1 : (res_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.action         = res_reg.action;
    assign result.syn_retrans_id = res_reg.id;
    assign result.syn_ts         = res_reg.ts;
    assign result.cohort_count   = res_reg.count;
    assign result.out_peer_addr  = res_reg.addr;
    assign result.out_peer_port  = res_reg.port;
    assign result.last           = res_reg.last;

endmodule

`default_nettype wire

/* sv/multicast_sender_handshake_core.sv */
`default_nettype none

// Sender side of a multicast join handshake. Start, tick and received-packet
// requests are accepted one per cycle by the front end while the queue has
// room and no cohort is being listed. The front end holds the phase, attempt
// id, SYN time, tick countdown and a 16-entry peer table searched in parallel
// for duplicates. Each request yields at most one command into a two-entry
// queue; the back end turns commands into results through an output register.
// A completed cohort of N peers produces a START and N peer entries, one per
// cycle as the output is taken, reading the table through a single read port;
// until the last entry is registered no new request is accepted.
// Configuration is written through the APB port at byte addresses 0, 4 and 8.
module multicast_sender_handshake_core
    import mshs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    mshs_req_if.sink                   item,
    mshs_res_if.source                 result
);

    cfg_t             cfg_reg, cfg_next;
    logic             cfg_wr;
    logic             q_push, q_full, q_pop, q_valid;
    cmd_t             q_push_cmd, q_pop_cmd;
    logic [IDX_W-1:0] rd_idx;
    peer_t            rd_peer;
    logic             list_done;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_EXPECTED: cfg_next.need_peers = pwdata[RCV_W-1:0];
                REG_RETRIES:  cfg_next.retries    = pwdata[RETRY_W-1:0];
                REG_RTO:      cfg_next.rto_ticks  = pwdata[RTO_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_EXPECTED: prdata = APB_DATA_W'(cfg_reg.need_peers);
            REG_RETRIES:  prdata = APB_DATA_W'(cfg_reg.retries);
            REG_RTO:      prdata = APB_DATA_W'(cfg_reg.rto_ticks);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{need_peers: EXPECTED_RST,
                         retries:    RETRIES_RST,
                         rto_ticks:  RTO_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // request classification and handshake state
    mshs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg_reg),
        .push      (q_push),
        .cmd       (q_push_cmd),
        .q_full    (q_full),
        .list_done (list_done),
        .rd_idx    (rd_idx),
        .rd_peer   (rd_peer)
    );

    // command queue
    mshs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_pop_cmd)
    );

    // result generation
    mshs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_pop_cmd),
        .pop       (q_pop),
        .rd_idx    (rd_idx),
        .rd_peer   (rd_peer),
        .list_done (list_done),
        .result    (result)
    );

    // queue never written when full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("command pushed into full queue");

    // queue never read when empty
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("command popped from empty queue");

    // cohort count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.cohort_count <= OUT_CNT_W'(PEERS)))
        else $error("cohort count beyond table size");

endmodule

`default_nettype wire

/* tb/sv/multicast_sender_handshake_checker.sv */
`timescale 1ns / 100ps

module multicast_sender_handshake_checker
    import mshs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    mshs_req_if                   item,
    mshs_res_if                   result,
    output int                    fail_count,
    output int                    results_due
);

    // register copies
    logic [RCV_W-1:0]   exp_receivers;
    logic [RETRY_W-1:0] max_retries;
    logic [RTO_W-1:0]   wait_ticks;

    // handshake state as the block should hold it
    phase_t      phase;
    logic [3:0]  attempt;
    logic [31:0] syn_time;
    logic [15:0] ticks_left;
    peer_t       peers [PEERS];
    logic [4:0]  cohort;

    // results still owed by the block, oldest first
    res_t due_results [$];

    task automatic queue_result(input action_t act, input logic [3:0] id,
                                input logic [31:0] ts, input logic [31:0] addr,
                                input logic [15:0] port, input logic last);
        res_t r;
        r.action = act;
        r.id     = id;
        r.ts     = ts;
        r.count  = cohort;
        r.addr   = addr;
        r.port   = port;
        r.last   = last;
        due_results.insert(due_results.size(), r);
    endtask

    task automatic open_attempt(input logic [3:0] id, input logic [31:0] now);
        attempt    = id;
        syn_time   = now;
        ticks_left = wait_ticks;
        cohort     = '0;
        phase      = PH_WAIT;
    endtask

    // one accepted request moves the handshake on
    task automatic advance_handshake();
        int   limit;
        logic seen;
        limit = int'(max_retries) + 1;
        if (limit > MAX_ATTEMPTS)
            limit = MAX_ATTEMPTS;
        seen = 1'b0;
        if (item.func == FN_START)
        begin
            if (exp_receivers == '0)
            begin
                // nobody to wait for: give up at once
                cohort  = '0;
                attempt = '0;
                phase   = PH_FAIL;
                queue_result(ACT_FAIL, '0, '0, '0, '0, 1'b1);
            end
            else
            begin
                open_attempt(4'd1, item.now_ms);
                queue_result(ACT_SYN, attempt, syn_time, '0, '0, 1'b1);
            end
        end
        else if (phase == PH_WAIT && item.func == FN_TICK)
        begin
            if (ticks_left != '0)
                ticks_left = ticks_left - 16'd1;
            if (ticks_left == '0)
            begin
                if (int'(attempt) < limit)
                begin
                    open_attempt(attempt + 4'd1, item.now_ms);
                    queue_result(ACT_SYN, attempt, syn_time, '0, '0, 1'b1);
                end
                else
                begin
                    phase = PH_FAIL;
                    queue_result(ACT_FAIL, attempt, '0, '0, '0, 1'b1);
                end
            end
        end
        else if (phase == PH_WAIT && item.func == FN_PKT)
        begin
            if (item.checksum_ok && item.has_syn && item.has_ack &&
                item.pkt_retrans_id == {4'd0, attempt} && item.pkt_echo_ts == syn_time)
            begin
                // duplicate search over the filled part of the table
                for (int i = 0; i < PEERS; i++)
                    if (i < cohort && peers[i].addr == item.peer_addr &&
                        peers[i].port == item.peer_port)
                        seen = 1'b1;
                if (!seen && cohort < PEERS)
                begin
                    peers[cohort[3:0]] = {item.peer_addr, item.peer_port};
                    cohort = cohort + 5'd1;
                end
                if (cohort >= exp_receivers)
                begin
                    phase = PH_DONE;
                    queue_result(ACT_START, 4'd1, item.now_ms, '0, '0, cohort == '0);
                    for (int i = 0; i < PEERS; i++)
                        if (i < cohort)
                            queue_result(ACT_PEER, '0, '0, peers[i].addr, peers[i].port,
                                         i + 1 == cohort);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            exp_receivers = EXPECTED_RST;
            max_retries   = RETRIES_RST;
            wait_ticks    = RTO_RST;
            phase         = PH_IDLE;
            attempt       = '0;
            syn_time      = '0;
            ticks_left    = '0;
            cohort        = '0;
            for (int i = 0; i < PEERS; i++)
                peers[i] = '0;
            due_results.delete();
            fail_count    = 0;
            results_due   = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_EXPECTED: exp_receivers = pwdata[RCV_W-1:0];
                    REG_RETRIES:  max_retries   = pwdata[RETRY_W-1:0];
                    REG_RTO:      wait_ticks    = pwdata[RTO_W-1:0];
                    default: ;
                endcase

            // accepted request
            if (item.valid && item.ready)
                advance_handshake();

            // accepted result against the oldest one owed
            if (result.valid && result.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: action %0d", result.action);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("action", want.action, result.action);
                    check_field("syn_retrans_id", want.id, result.syn_retrans_id);
                    check_field("syn_ts", want.ts, result.syn_ts);
                    check_field("cohort_count", want.count, result.cohort_count);
                    check_field("out_peer_addr", want.addr, result.out_peer_addr);
                    check_field("out_peer_port", want.port, result.out_peer_port);
                    check_field("last", want.last, result.last);
                end
            end
            results_due = due_results.size();
        end
    end

endmodule

/* tb/sv/multicast_sender_handshake_core_tb.sv */
`timescale 1ns / 100ps

module multicast_sender_handshake_core_tb;
    import mshs_pkg::*;

    localparam int ITEMS       = 230;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL        = 24;

    // func value the block has no use for
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic        checksum_ok;
        logic        has_syn;
        logic        has_ack;
        logic [7:0]  rid;
        logic [31:0] echo_ts;
        peer_t       peer;
    } join_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int results_due;
    int cycles;
    int req_gap_max   = 6;
    int res_stall_max = 6;
    int counted_items;

    // sender's own view of the handshake, to aim replies at the live attempt
    logic [RCV_W-1:0]   cfg_expected = EXPECTED_RST;
    logic [RETRY_W-1:0] cfg_retries  = RETRIES_RST;
    logic [RTO_W-1:0]   cfg_rto      = RTO_RST;
    logic [3:0]         cur_attempt;
    logic [31:0]        cur_syn_ts;
    logic [15:0]        ticks_left;
    logic               waiting = 1'b0;
    peer_t              pool [POOL];

    mshs_req_if item();
    mshs_res_if result();

    multicast_sender_handshake_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item),
        .result  (result)
    );

    multicast_sender_handshake_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .item        (item),
        .result      (result),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls before each result is taken
    initial
    begin : drain
        int stall;
        result.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, res_stall_max);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
        end
    end

    function automatic join_req_t random_req(input logic [1:0] fn);
        join_req_t r;
        r.func        = fn;
        r.now_ms      = $urandom();
        r.checksum_ok = 1'($urandom());
        r.has_syn     = 1'($urandom());
        r.has_ack     = 1'($urandom());
        r.rid         = 8'($urandom());
        r.echo_ts     = $urandom();
        r.peer.addr   = $urandom();
        r.peer.port   = 16'($urandom());
        return r;
    endfunction

    // reply that passes every check for the live attempt
    function automatic join_req_t good_reply(input peer_t p);
        join_req_t r;
        r             = random_req(FN_PKT);
        r.checksum_ok = 1'b1;
        r.has_syn     = 1'b1;
        r.has_ack     = 1'b1;
        r.rid         = {4'd0, cur_attempt};
        r.echo_ts     = cur_syn_ts;
        r.peer        = p;
        return r;
    endfunction

    // spoil one check of a good reply
    function automatic join_req_t broken_reply(input join_req_t r, input int flaw);
        case (flaw)
            0: r.checksum_ok = 1'b0;
            1: r.has_syn     = 1'b0;
            2: r.has_ack     = 1'b0;
            3: r.rid         = r.rid ^ 8'($urandom_range(1, 255));
            default: r.echo_ts = r.echo_ts ^ ($urandom() | 32'd1);
        endcase
        return r;
    endfunction

    // present one request and wait for it to be taken
    task automatic send_req(input join_req_t r);
        int gap;
        int limit;
        gap   = $urandom_range(0, req_gap_max);
        limit = int'(cfg_retries) + 1;
        if (limit > MAX_ATTEMPTS)
            limit = MAX_ATTEMPTS;
        // follow attempt id and SYN time so later replies can match
        if (r.func == FN_START)
        begin
            waiting     = cfg_expected != '0;
            cur_attempt = 4'd1;
            cur_syn_ts  = r.now_ms;
            ticks_left  = cfg_rto;
        end
        else if (r.func == FN_TICK && waiting)
        begin
            if (ticks_left != '0)
                ticks_left = ticks_left - 16'd1;
            if (ticks_left == '0)
            begin
                if (int'(cur_attempt) < limit)
                begin
                    cur_attempt = cur_attempt + 4'd1;
                    cur_syn_ts  = r.now_ms;
                    ticks_left  = cfg_rto;
                end
                else
                    waiting = 1'b0;
            end
        end
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid          <= 1'b1;
        item.func           <= r.func;
        item.now_ms         <= r.now_ms;
        item.checksum_ok    <= r.checksum_ok;
        item.has_syn        <= r.has_syn;
        item.has_ack        <= r.has_ack;
        item.pkt_retrans_id <= r.rid;
        item.pkt_echo_ts    <= r.echo_ts;
        item.peer_addr      <= r.peer.addr;
        item.peer_port      <= r.peer.port;
        do @(posedge clk); while (!item.ready);
        counted_items++;
    endtask

    // hold requests until every owed result is out and the block has settled
    task automatic wait_idle();
        item.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [RCV_W-1:0] expected, input logic [RETRY_W-1:0] tries,
                              input logic [RTO_W-1:0] rto);
        wait_idle();
        write_reg(REG_EXPECTED, 32'(expected));
        write_reg(REG_RETRIES, 32'(tries));
        write_reg(REG_RTO, 32'(rto));
        cfg_expected = expected;
        cfg_retries  = tries;
        cfg_rto      = rto;
    endtask

    // one handshake: start, then mostly well-formed replies mixed with noise
    task automatic run_session();
        join_req_t r;
        int        roll;
        int        next_peer;
        int        n_items;
        next_peer     = 0;
        n_items       = $urandom_range(3, 2 * int'(cfg_expected) + 10);
        if (n_items > 40)
            n_items = 40;
        req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 6;
        res_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;

        // peer pool, some sharing an address or a port with a neighbour
        for (int i = 0; i < POOL; i++)
        begin
            pool[i].addr = $urandom();
            pool[i].port = 16'($urandom());
            if (i > 0 && $urandom_range(0, 3) == 0)
                pool[i].addr = pool[i-1].addr;
            else if (i > 0 && $urandom_range(0, 3) == 0)
                pool[i].port = pool[i-1].port;
        end

        send_req(random_req(FN_START));
        for (int k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    r = good_reply(pool[next_peer % POOL]);
                    next_peer++;
                end
                else
                    r = good_reply(pool[$urandom_range(0, POOL - 1)]);
            end
            else if (roll < 67)
                r = broken_reply(good_reply(pool[$urandom_range(0, POOL - 1)]),
                                 $urandom_range(0, 4));
            else if (roll < 85)
                r = random_req(FN_TICK);
            else if (roll < 90)
                r = random_req(FN_UNUSED);
            else if (roll < 95)
                r = random_req(FN_PKT);
            else
            begin
                // restart mid-handshake, sometimes after letting everything drain
                if (roll == 99)
                    wait_idle();
                r = random_req(FN_START);
            end
            send_req(r);
        end

        // with short waits, sometimes tick on until the attempts run out
        if (cfg_rto <= 16'd6 && $urandom_range(0, 1) == 1)
            while (waiting)
                send_req(random_req(FN_TICK));
    endtask

    initial
    begin : stimulus
        join_req_t r;
        peer_t     a;
        peer_t     b;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        item.valid          <= 1'b0;
        item.func           <= '0;
        item.now_ms         <= '0;
        item.checksum_ok    <= 1'b0;
        item.has_syn        <= 1'b0;
        item.has_ack        <= 1'b0;
        item.pkt_retrans_id <= '0;
        item.pkt_echo_ts    <= '0;
        item.peer_addr      <= '0;
        item.peer_port      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // requests outside a handshake are dropped
        send_req(random_req(FN_TICK));
        send_req(random_req(FN_PKT));
        send_req(random_req(FN_UNUSED));

        // start at the top of the time range, then replies failing one check each
        r = random_req(FN_START);
        r.now_ms = '1;
        send_req(r);
        a.addr = '1;
        a.port = '1;
        b      = '0;
        for (int k = 0; k < 5; k++)
            send_req(broken_reply(good_reply(a), k));
        send_req(good_reply(a));
        send_req(random_req(FN_TICK));

        // start at time zero with an all-zero peer
        r = random_req(FN_START);
        r.now_ms = '0;
        send_req(r);
        send_req(good_reply(b));

        // no receivers expected: start fails at once
        set_config('0, '0, '0);
        send_req(random_req(FN_START));

        // zero wait times out on the first tick, single attempt
        set_config(5'd2, '0, '0);
        send_req(random_req(FN_START));
        send_req(random_req(FN_TICK));

        // two attempts, a duplicate peer, then failure with one peer held
        set_config(5'd2, 8'd1, 16'd1);
        send_req(random_req(FN_START));
        send_req(random_req(FN_TICK));
        send_req(good_reply(a));
        send_req(good_reply(a));
        send_req(random_req(FN_TICK));

        // restart and complete a cohort of two around a duplicate
        send_req(random_req(FN_START));
        send_req(good_reply(a));
        send_req(good_reply(a));
        send_req(good_reply(b));

        // settings at the extremes, then random ones
        set_config(5'd16, 8'd255, 16'd30);
        run_session();
        run_session();
        set_config(5'd2, 8'd255, 16'd1);
        run_session();
        run_session();
        set_config(5'd1, '0, 16'd65535);
        run_session();
        set_config(5'd31, 8'd7, 16'd2);
        run_session();
        set_config(5'd3, 8'd1, '0);
        run_session();
        while (counted_items < ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
                set_config(5'($urandom_range(1, 6)), 8'($urandom_range(0, 9)),
                           16'($urandom_range(0, 6)));
            run_session();
        end

        wait_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
sv/mshs_pkg.sv
sv/mshs_if.sv
sv/mshs_front.sv
sv/mshs_queue.sv
sv/mshs_back.sv
sv/multicast_sender_handshake_core.sv
tb/sv/multicast_sender_handshake_checker.sv
tb/sv/multicast_sender_handshake_core_tb.sv
